// ===== design/pgps_pkg.sv =====
// Shared constants, codes and types of the polygon grid point scan.
`timescale 1ns / 1ps
`default_nettype none
package pgps_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 32;
  localparam int VTX_W        = 2 * COORD_W;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int SPACING_W    = 31;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam int CFG_IDX_W    = CFG_AW - 2;

  localparam logic [SPACING_W-1:0] SPACING_RESET    = SPACING_W'(65536);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SPACING = CFG_IDX_W'(0);

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TEST = 2'd1,
    OP_SCAN = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_END  = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } fsm_t;

  // one edge (vertex i, vertex j) against the point under test
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] xi;
    logic signed [COORD_W-1:0] yi;
    logic signed [COORD_W-1:0] xj;
    logic signed [COORD_W-1:0] yj;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } edge_req_t;

  typedef struct packed {
    logic busy;
    logic hit_valid;
    logic hit;
  } edge_stat_t;

endpackage
`default_nettype wire

// ===== design/pgps_in_if.sv =====
// Input channel: operation, vertex or point, with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface pgps_in_if;
  logic                                        valid;
  logic                                        ready;
  logic [1:0]                                  operation;
  logic                                        first_vertex;
  logic signed [pgps_pkg::COORD_W-1:0]         x_coord;
  logic signed [pgps_pkg::COORD_W-1:0]         y_coord;

  modport source (output valid, operation, first_vertex, x_coord, y_coord, input ready);
  modport sink   (input valid, operation, first_vertex, x_coord, y_coord, output ready);
endinterface
`default_nettype wire

// ===== design/pgps_out_if.sv =====
// Result channel: point, inside flag, last flag and status, with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface pgps_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pgps_pkg::COORD_W-1:0] result_x;
  logic signed [pgps_pkg::COORD_W-1:0] result_y;
  logic                                inside_res;
  logic                                last_point;
  logic [1:0]                          status;

  modport source (output valid, result_x, result_y, inside_res, last_point, status,
                  input ready);
  modport sink   (input valid, result_x, result_y, inside_res, last_point, status,
                  output ready);
endinterface
`default_nettype wire

// ===== design/pgps_vram.sv =====
// Vertex store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pgps_vram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== design/pgps_edge.sv =====
// Edge crossing unit: differences, cross-multiplication, sign-aware compare.
`timescale 1ns / 1ps
`default_nettype none
module pgps_edge (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pgps_pkg::edge_req_t  req_i,
  output pgps_pkg::edge_stat_t      stat_o
);

  logic signed [pgps_pkg::COORD_W-1:0] xi, yi, xj, yj, px, py;
  logic                                cross_c;

  // difference stage
  logic                               a_valid_r, a_valid_nxt;
  logic signed [pgps_pkg::DIFF_W-1:0] d_r, a_r, b_r, c_r;

  // product stage
  logic                               b_valid_r, b_valid_nxt;
  logic                               dpos_r;
  logic signed [pgps_pkg::PROD_W-1:0] lhs_r, rhs_r;

  assign xi = $signed(req_i.xi);
  assign yi = $signed(req_i.yi);
  assign xj = $signed(req_i.xj);
  assign yj = $signed(req_i.yj);
  assign px = $signed(req_i.px);
  assign py = $signed(req_i.py);

  // only edges that straddle the horizontal through the point go on
  assign cross_c     = (yi > py) != (yj > py);
  assign a_valid_nxt = req_i.valid && cross_c;
  assign b_valid_nxt = a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= pgps_pkg::DIFF_W'(yj) - pgps_pkg::DIFF_W'(yi);
    a_r    <= pgps_pkg::DIFF_W'(px) - pgps_pkg::DIFF_W'(xi);
    b_r    <= pgps_pkg::DIFF_W'(xj) - pgps_pkg::DIFF_W'(xi);
    c_r    <= pgps_pkg::DIFF_W'(py) - pgps_pkg::DIFF_W'(yi);
    dpos_r <= d_r > pgps_pkg::DIFF_W'(0);
    lhs_r  <= pgps_pkg::PROD_W'(a_r) * pgps_pkg::PROD_W'(d_r);
    rhs_r  <= pgps_pkg::PROD_W'(b_r) * pgps_pkg::PROD_W'(c_r);
  end

  assign stat_o.busy      = a_valid_r || b_valid_r;
  assign stat_o.hit_valid = b_valid_r;
  assign stat_o.hit       = dpos_r ? (lhs_r < rhs_r) : (rhs_r < lhs_r);

endmodule
`default_nettype wire

// ===== design/polygon_grid_point_scan.sv =====
// Top level of the polygon grid point scan: sequencer, state and ports.
`timescale 1ns / 1ps
`default_nettype none
// Loads polygon vertices (signed Q15.16) one per transaction, keeps their
// bounding box, answers point-in-polygon tests by crossing number and walks
// a grid over the box, row by row from the minimum corner, one point per scan
// transaction. Every input transaction gives exactly one result transaction.
// Sequence: a load, an empty or finished scan, or an unused operation is
// decoded and its result loaded into the result register, after which the
// block accepts again. A test or scan step with n >= 3 stored vertices is
// decoded, then makes n + 1 reads from the read port of the vertex store
// (the closing vertex primes, then one edge per cycle), empties the read and
// the difference and product stages, loads the result register once it is free
// and returns to idle to accept the next transaction. With fewer than three
// vertices the point is reported outside and the walk is skipped. One
// transaction is in work at a time; the result register lets the next
// transaction be accepted while an earlier result still waits on out_ch.ready.
// grid_spacing is the only register (byte address 0); write it only while
// the block is idle. A spacing of zero is treated as one LSB.
module polygon_grid_point_scan (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  pgps_in_if.sink                              in_ch,
  pgps_out_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pgps_pkg::CFG_AW-1:0]     paddr,
  input  wire logic [pgps_pkg::CFG_DW-1:0]     pwdata,
  output logic      [pgps_pkg::CFG_DW-1:0]     prdata,
  output logic                                 pready
);

  localparam int CW = pgps_pkg::COORD_W;
  localparam int DW = pgps_pkg::DIFF_W;

  // sequencer
  pgps_pkg::fsm_t state_r, state_nxt;

  // latched transaction
  logic [1:0]           op_r;
  logic                 first_r;
  logic signed [CW-1:0] x_r, y_r;

  // configuration
  logic [pgps_pkg::SPACING_W-1:0] spacing_r, spacing_nxt;

  // polygon and scan state
  logic [pgps_pkg::CNT_W-1:0] count_r, count_nxt;
  logic signed [CW-1:0]       bminx_r, bmaxx_r, bminy_r, bmaxy_r;
  logic signed [CW-1:0]       bminx_nxt, bmaxx_nxt, bminy_nxt, bmaxy_nxt;
  logic signed [CW-1:0]       scan_x_r, scan_y_r, scan_x_nxt, scan_y_nxt;
  pgps_pkg::phase_t           phase_r, phase_nxt;

  // point under test and pending result
  logic signed [CW-1:0]       px_r, py_r, px_nxt, py_nxt;
  logic signed [CW-1:0]       res_x_r, res_y_r, res_x_nxt, res_y_nxt;
  logic                       res_last_r, res_last_nxt;
  pgps_pkg::status_t          res_status_r, res_status_nxt;
  logic                       inside_r, inside_nxt;

  // edge walk
  logic [pgps_pkg::CNT_W-1:0] k_r, k_nxt;
  logic                       rd_valid_r, rd_valid_nxt;
  logic                       rd_prime_r, rd_prime_nxt;
  logic [pgps_pkg::VTX_W-1:0] prev_r;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic                 out_inside_r, out_last_r;
  pgps_pkg::status_t    out_status_r;
  logic                 out_load;

  // vertex store ports
  logic                        we_c, re_c;
  logic [pgps_pkg::ADDR_W-1:0] waddr_c, raddr_c;
  logic [pgps_pkg::VTX_W-1:0]  wdata_c, rdata_c;

  // edge unit
  pgps_pkg::edge_req_t  edge_req;
  pgps_pkg::edge_stat_t edge_stat;

  // scratch for load and scan
  logic [pgps_pkg::CNT_W-1:0]     cnt_eff;
  logic                           store_full;
  logic [pgps_pkg::SPACING_W-1:0] spc_eff;
  logic signed [DW-1:0]           step_c, nx_c, ny_c;
  logic signed [CW-1:0]           rx_c, ry_c;
  logic                           cfg_wr;
  logic                           in_acc;

  pgps_vram #(
    .DEPTH (pgps_pkg::MAX_VERTICES),
    .WIDTH (pgps_pkg::VTX_W)
  ) u_vram (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .re    (re_c),
    .raddr (raddr_c),
    .rdata (rdata_c)
  );

  pgps_edge u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (edge_req),
    .stat_o (edge_stat)
  );

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[pgps_pkg::CFG_AW-1:2] == pgps_pkg::REG_GRID_SPACING);
  assign spacing_nxt = cfg_wr ? pwdata[pgps_pkg::SPACING_W-1:0] : spacing_r;
  assign prdata = (paddr[pgps_pkg::CFG_AW-1:2] == pgps_pkg::REG_GRID_SPACING) ?
                  {{(pgps_pkg::CFG_DW - pgps_pkg::SPACING_W){1'b0}}, spacing_r} :
                  '0;

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  assign in_ch.ready = (state_r == pgps_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.result_x   = out_x_r;
  assign out_ch.result_y   = out_y_r;
  assign out_ch.inside_res = out_inside_r;
  assign out_ch.last_point = out_last_r;
  assign out_ch.status     = out_status_r;

  // ---------------------------------------------------------------------
  // Edge feed: the current read is vertex i, the one before it vertex j.
  // The first read of a walk fetches the closing vertex and only primes j.
  // ---------------------------------------------------------------------
  assign edge_req.valid = rd_valid_r && !rd_prime_r;
  assign edge_req.xi    = rdata_c[CW-1:0];
  assign edge_req.yi    = rdata_c[pgps_pkg::VTX_W-1:CW];
  assign edge_req.xj    = prev_r[CW-1:0];
  assign edge_req.yj    = prev_r[pgps_pkg::VTX_W-1:CW];
  assign edge_req.px    = px_r;
  assign edge_req.py    = py_r;

  // ---------------------------------------------------------------------
  // Scan arithmetic: next grid point, compared without wrapping
  // ---------------------------------------------------------------------
  assign spc_eff = (spacing_r == '0) ? pgps_pkg::SPACING_W'(1) : spacing_r;
  assign step_c  = $signed(DW'(spc_eff));
  assign rx_c    = (phase_r == pgps_pkg::PH_IDLE) ? bminx_r : scan_x_r;
  assign ry_c    = (phase_r == pgps_pkg::PH_IDLE) ? bminy_r : scan_y_r;
  assign nx_c    = DW'(rx_c) + step_c;
  assign ny_c    = DW'(ry_c) + step_c;

  // load: a first vertex clears the polygon before the capacity check
  assign cnt_eff    = first_r ? '0 : count_r;
  assign store_full = cnt_eff >= pgps_pkg::CNT_W'(pgps_pkg::MAX_VERTICES);

  // ---------------------------------------------------------------------
  // Sequencer: next state and datapath updates
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    bminx_nxt      = bminx_r;
    bmaxx_nxt      = bmaxx_r;
    bminy_nxt      = bminy_r;
    bmaxy_nxt      = bmaxy_r;
    scan_x_nxt     = scan_x_r;
    scan_y_nxt     = scan_y_r;
    phase_nxt      = phase_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_last_nxt   = res_last_r;
    res_status_nxt = res_status_r;
    inside_nxt     = inside_r;
    k_nxt          = k_r;
    rd_valid_nxt   = 1'b0;
    rd_prime_nxt   = 1'b0;
    we_c           = 1'b0;
    waddr_c        = cnt_eff[pgps_pkg::ADDR_W-1:0];
    wdata_c        = {y_r, x_r};
    re_c           = 1'b0;
    raddr_c        = '0;
    out_load       = 1'b0;

    // flip the crossing parity for every edge the unit reports as hit
    if (edge_stat.hit_valid && edge_stat.hit) begin
      inside_nxt = !inside_r;
    end

    unique case (state_r)
      pgps_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = pgps_pkg::S_EXEC;
        end
      end

      pgps_pkg::S_EXEC: begin
        res_x_nxt      = '0;
        res_y_nxt      = '0;
        res_last_nxt   = 1'b0;
        res_status_nxt = pgps_pkg::STAT_OK;
        inside_nxt     = 1'b0;
        k_nxt          = '0;
        state_nxt      = pgps_pkg::S_FINISH;
        unique case (pgps_pkg::op_t'(op_r))
          pgps_pkg::OP_LOAD: begin
            // every load restarts the scan, stored or dropped
            res_x_nxt = x_r;
            res_y_nxt = y_r;
            phase_nxt = pgps_pkg::PH_IDLE;
            count_nxt = cnt_eff;
            if (store_full) begin
              res_status_nxt = pgps_pkg::STAT_FULL;
            end else begin
              we_c      = 1'b1;
              count_nxt = cnt_eff + pgps_pkg::CNT_W'(1);
              if (cnt_eff == '0) begin
                bminx_nxt = x_r;
                bmaxx_nxt = x_r;
                bminy_nxt = y_r;
                bmaxy_nxt = y_r;
              end else begin
                if (x_r < bminx_r) bminx_nxt = x_r;
                if (x_r > bmaxx_r) bmaxx_nxt = x_r;
                if (y_r < bminy_r) bminy_nxt = y_r;
                if (y_r > bmaxy_r) bmaxy_nxt = y_r;
              end
            end
          end

          pgps_pkg::OP_TEST: begin
            res_x_nxt = x_r;
            res_y_nxt = y_r;
            px_nxt    = x_r;
            py_nxt    = y_r;
            if (count_r >= pgps_pkg::CNT_W'(3)) begin
              state_nxt = pgps_pkg::S_WALK;
            end
          end

          pgps_pkg::OP_SCAN: begin
            if (count_r == '0 || phase_r == pgps_pkg::PH_DONE) begin
              // nothing to scan: hold the state
              res_status_nxt = pgps_pkg::STAT_END;
            end else begin
              res_x_nxt = rx_c;
              res_y_nxt = ry_c;
              px_nxt    = rx_c;
              py_nxt    = ry_c;
              scan_x_nxt = rx_c;
              scan_y_nxt = ry_c;
              if (nx_c <= DW'(bmaxx_r)) begin
                scan_x_nxt = nx_c[CW-1:0];
                phase_nxt  = pgps_pkg::PH_RUN;
              end else if (ny_c <= DW'(bmaxy_r)) begin
                scan_x_nxt = bminx_r;
                scan_y_nxt = ny_c[CW-1:0];
                phase_nxt  = pgps_pkg::PH_RUN;
              end else begin
                res_last_nxt = 1'b1;
                phase_nxt    = pgps_pkg::PH_DONE;
              end
              if (count_r >= pgps_pkg::CNT_W'(3)) begin
                state_nxt = pgps_pkg::S_WALK;
              end
            end
          end

          default: begin
            // unused operation: all-zero result
          end
        endcase
      end

      pgps_pkg::S_WALK: begin
        // read the closing vertex first, then vertices 0 .. n-1 in order
        re_c         = 1'b1;
        rd_valid_nxt = 1'b1;
        rd_prime_nxt = (k_r == '0);
        raddr_c      = (k_r == '0) ? pgps_pkg::ADDR_W'(count_r - pgps_pkg::CNT_W'(1)) :
                                     pgps_pkg::ADDR_W'(k_r - pgps_pkg::CNT_W'(1));
        k_nxt        = k_r + pgps_pkg::CNT_W'(1);
        if (k_r == count_r) begin
          state_nxt = pgps_pkg::S_DRAIN;
        end
      end

      pgps_pkg::S_DRAIN: begin
        if (!rd_valid_r && !edge_stat.busy && !edge_stat.hit_valid) begin
          state_nxt = pgps_pkg::S_FINISH;
        end
      end

      pgps_pkg::S_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = pgps_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pgps_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pgps_pkg::S_IDLE;
      spacing_r   <= pgps_pkg::SPACING_RESET;
      count_r     <= '0;
      bminx_r     <= '0;
      bmaxx_r     <= '0;
      bminy_r     <= '0;
      bmaxy_r     <= '0;
      scan_x_r    <= '0;
      scan_y_r    <= '0;
      phase_r     <= pgps_pkg::PH_IDLE;
      k_r         <= '0;
      rd_valid_r  <= 1'b0;
      rd_prime_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spacing_r   <= spacing_nxt;
      count_r     <= count_nxt;
      bminx_r     <= bminx_nxt;
      bmaxx_r     <= bmaxx_nxt;
      bminy_r     <= bminy_nxt;
      bmaxy_r     <= bmaxy_nxt;
      scan_x_r    <= scan_x_nxt;
      scan_y_r    <= scan_y_nxt;
      phase_r     <= phase_nxt;
      k_r         <= k_nxt;
      rd_valid_r  <= rd_valid_nxt;
      rd_prime_r  <= rd_prime_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_ch.operation;
      first_r <= in_ch.first_vertex;
      x_r     <= in_ch.x_coord;
      y_r     <= in_ch.y_coord;
    end
    if (rd_valid_r) begin
      prev_r <= rdata_c;
    end
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    res_x_r      <= res_x_nxt;
    res_y_r      <= res_y_nxt;
    res_last_r   <= res_last_nxt;
    res_status_r <= res_status_nxt;
    inside_r     <= inside_nxt;
    if (out_load) begin
      out_x_r      <= res_x_r;
      out_y_r      <= res_y_r;
      out_inside_r <= inside_r;
      out_last_r   <= res_last_r;
      out_status_r <= res_status_r;
    end
  end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the polygon grid point scan: directed table, then random phases.
`timescale 1ns / 1ps
module tb_top;
  import pgps_pkg::*;

  // Run limit: about 830 transactions in the slowest correct case (full store,
  // longest stalls on both sides), taken several times over.
  localparam int CYCLE_LIMIT = 400_000;
  localparam int PHASE_ITEMS = 160;
  localparam int NUM_PHASES  = 5;
  localparam int END_WAIT    = 60;

  localparam logic [CFG_AW-1:0] SPACING_ADDR = {REG_GRID_SPACING, 2'b00};

  localparam logic [COORD_W-1:0] Q_ZERO   = 32'h0000_0000;
  localparam logic [COORD_W-1:0] Q_ONE    = 32'h0001_0000;
  localparam logic [COORD_W-1:0] Q_FOUR   = 32'h0004_0000;
  localparam logic [COORD_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [COORD_W-1:0] MOST_POS = 32'h7FFF_FFFF;

  // One result transaction as the block should present it.
  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic                      in_poly;
    logic                      last;
    status_t                   status;
  } answer_t;

  // One row of the directed table: either a spacing write (value in x) or a
  // transaction, with the answer typed in where it is obvious.
  typedef struct packed {
    logic               spacing_row;
    op_t                op;
    logic               first;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               typed;
    answer_t            want;
  } drow_t;

  localparam answer_t NO_ANSWER = '0;
  localparam answer_t SCAN_DONE = '{Q_ZERO, Q_ZERO, 1'b0, 1'b0, STAT_END};

  // Directed part. The store-full case needs more than 32 loads and is left to the
  // random phases, which fill the store past capacity on purpose.
  localparam int NUM_ROWS = 26;
  localparam drow_t DIRECTED_ROWS [NUM_ROWS] = '{
    // scan straight after reset, nothing loaded: no area
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b1, SCAN_DONE},
    // test with an empty polygon at the coordinate extremes: echoed, outside
    '{1'b0, OP_TEST, 1'b0, MOST_POS, MOST_NEG, 1'b1,
      '{MOST_POS, MOST_NEG, 1'b0, 1'b0, STAT_OK}},
    // unused operation: all fields zero, no state change
    '{1'b0, OP_NONE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_ANSWER},
    // right triangle (0,0) (4,0) (0,4), probed with two vertices loaded too
    '{1'b0, OP_LOAD, 1'b1, Q_ZERO, Q_ZERO, 1'b1,
      '{Q_ZERO, Q_ZERO, 1'b0, 1'b0, STAT_OK}},
    '{1'b0, OP_LOAD, 1'b0, Q_FOUR, Q_ZERO, 1'b1,
      '{Q_FOUR, Q_ZERO, 1'b0, 1'b0, STAT_OK}},
    '{1'b0, OP_TEST, 1'b0, Q_ONE, Q_ZERO, 1'b1,
      '{Q_ONE, Q_ZERO, 1'b0, 1'b0, STAT_OK}},
    '{1'b0, OP_LOAD, 1'b0, Q_ZERO, Q_FOUR, 1'b1,
      '{Q_ZERO, Q_FOUR, 1'b0, 1'b0, STAT_OK}},
    '{1'b0, OP_TEST, 1'b0, Q_ONE, Q_ONE, 1'b0, NO_ANSWER},
    '{1'b0, OP_TEST, 1'b1, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    '{1'b0, OP_SCAN, 1'b1, MOST_POS, MOST_POS, 1'b0, NO_ANSWER},
    // triangle spanning the whole range; the first load restarts the scan
    '{1'b0, OP_LOAD, 1'b1, MOST_NEG, MOST_NEG, 1'b1,
      '{MOST_NEG, MOST_NEG, 1'b0, 1'b0, STAT_OK}},
    '{1'b0, OP_LOAD, 1'b0, MOST_POS, MOST_NEG, 1'b1,
      '{MOST_POS, MOST_NEG, 1'b0, 1'b0, STAT_OK}},
    '{1'b0, OP_LOAD, 1'b0, MOST_POS, MOST_POS, 1'b1,
      '{MOST_POS, MOST_POS, 1'b0, 1'b0, STAT_OK}},
    '{1'b0, OP_TEST, 1'b0, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    // widest spacing: three points per row, each row ends on a 32 bit overflow
    '{1'b1, OP_NONE, 1'b0, MOST_POS, Q_ZERO, 1'b0, NO_ANSWER},
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b0, NO_ANSWER},
    // one more step after the last grid point: scan finished
    '{1'b0, OP_SCAN, 1'b0, Q_ZERO, Q_ZERO, 1'b1, SCAN_DONE}
  };

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [CFG_DW-1:0]   pwdata;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  pgps_in_if  in_ch ();
  pgps_out_if out_ch ();

  polygon_grid_point_scan dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the block: polygon, bounding box, scan position and spacing.
  logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];
  int                        poly_len    = 0;
  logic signed [COORD_W-1:0] bmin_x      = '0;
  logic signed [COORD_W-1:0] bmax_x      = '0;
  logic signed [COORD_W-1:0] bmin_y      = '0;
  logic signed [COORD_W-1:0] bmax_y      = '0;
  logic signed [COORD_W-1:0] grid_x      = '0;
  logic signed [COORD_W-1:0] grid_y      = '0;
  phase_t                    grid_phase  = PH_IDLE;
  logic [SPACING_W-1:0]      spacing     = SPACING_RESET;

  answer_t expected_answers [$];
  answer_t typed_want;
  logic    typed_pending = 1'b0;

  int unsigned err_count     = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Crossing number against the shadow polygon. The edge division is replaced by
  // an exact 66 bit cross-multiplication; the comparison flips with the edge
  // direction so the sign of the denominator never matters.
  function automatic logic crossing_inside(input logic signed [COORD_W-1:0] px,
                                           input logic signed [COORD_W-1:0] py);
    logic                    odd;
    int                      i;
    int                      j;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dxp;
    logic signed [DIFF_W-1:0] dxe;
    logic signed [DIFF_W-1:0] dyp;
    logic signed [PROD_W-1:0] lhs;
    logic signed [PROD_W-1:0] rhs;
    odd = 1'b0;
    if (poly_len < 3) return 1'b0;
    j = poly_len - 1;
    for (i = 0; i < poly_len; i++) begin
      if ((poly_y[i] > py) != (poly_y[j] > py)) begin
        dy  = DIFF_W'(poly_y[j]) - DIFF_W'(poly_y[i]);
        dxp = DIFF_W'(px) - DIFF_W'(poly_x[i]);
        dxe = DIFF_W'(poly_x[j]) - DIFF_W'(poly_x[i]);
        dyp = DIFF_W'(py) - DIFF_W'(poly_y[i]);
        lhs = PROD_W'(dxp) * PROD_W'(dy);
        rhs = PROD_W'(dxe) * PROD_W'(dyp);
        if ((dy > 0) ? (lhs < rhs) : (rhs < lhs)) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  // Advance the shadow by one accepted transaction and return its answer.
  function automatic void predict_answer(input  op_t                       op,
                                         input  logic                      first,
                                         input  logic signed [COORD_W-1:0] x,
                                         input  logic signed [COORD_W-1:0] y,
                                         output answer_t                   ans);
    longint stride;
    longint nx;
    longint ny;
    ans = '0;
    case (op)
      OP_LOAD: begin
        if (first) poly_len = 0;
        // any load, stored or dropped, sends the next scan back to the corner
        grid_phase = PH_IDLE;
        ans.px = x;
        ans.py = y;
        if (poly_len >= MAX_VERTICES) begin
          ans.status = STAT_FULL;
        end else begin
          poly_x[poly_len] = x;
          poly_y[poly_len] = y;
          if (poly_len == 0) begin
            bmin_x = x;
            bmax_x = x;
            bmin_y = y;
            bmax_y = y;
          end else begin
            if (x < bmin_x) bmin_x = x;
            if (x > bmax_x) bmax_x = x;
            if (y < bmin_y) bmin_y = y;
            if (y > bmax_y) bmax_y = y;
          end
          poly_len++;
        end
      end
      OP_TEST: begin
        ans.px      = x;
        ans.py      = y;
        ans.in_poly = crossing_inside(x, y);
      end
      OP_SCAN: begin
        if (poly_len == 0 || grid_phase == PH_DONE) begin
          ans.status = STAT_END;
        end else begin
          if (grid_phase == PH_IDLE) begin
            grid_x = bmin_x;
            grid_y = bmin_y;
          end
          ans.px      = grid_x;
          ans.py      = grid_y;
          ans.in_poly = crossing_inside(grid_x, grid_y);
          // zero spacing behaves as one LSB; the sums are taken without wrapping
          stride = (spacing == 0) ? 64'sd1 : longint'(spacing);
          nx     = longint'(grid_x) + stride;
          if (nx <= longint'(bmax_x)) begin
            grid_x     = COORD_W'(nx);
            grid_phase = PH_RUN;
          end else begin
            ny = longint'(grid_y) + stride;
            if (ny <= longint'(bmax_y)) begin
              grid_x     = bmin_x;
              grid_y     = COORD_W'(ny);
              grid_phase = PH_RUN;
            end else begin
              ans.last   = 1'b1;
              grid_phase = PH_DONE;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Coordinate generator: mostly within +/- span, sometimes an extreme or anything.
  function automatic logic signed [COORD_W-1:0] rand_coord(input longint span);
    case ($urandom_range(39))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return $urandom();
      default: return COORD_W'(longint'($urandom_range(32'(2 * span))) - span);
    endcase
  endfunction

  // Drive one transaction, after random idle cycles at the set rate. Enter and
  // leave at a falling edge; valid stays high on return so that a back-to-back
  // transaction does not drop it within the same step.
  task automatic send_item(input op_t op, input logic first, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.first_vertex <= first;
    in_ch.x_coord      <= x;
    in_ch.y_coord      <= y;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Hold the sender until every outstanding answer has been collected.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_answers.size() != 0);
  endtask

  // One register access: setup cycle, then access cycle until pready.
  task automatic cfg_access(input logic wr, input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SPACING_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Drain, write grid_spacing, mirror it in the shadow and read it back.
  task automatic set_spacing(input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] rd;
    wait_for_results();
    cfg_access(1'b1, value, rd);
    spacing = value[SPACING_W-1:0];
    cfg_access(1'b0, '0, rd);
    check_field("grid_spacing", CFG_DW'(spacing), rd);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: drop ready at the set rate, re-drawn every cycle.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Checker and predictor, both on the rising edge: retire the oldest answer
  // first, then record the answer of any transaction accepted at this edge.
  always @(posedge clk) begin
    answer_t want;
    answer_t calc;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          err_count++;
          $display("%0t: result transaction with nothing expected, got x=%h y=%h in=%b last=%b st=%h",
                   $time, out_ch.result_x, out_ch.result_y, out_ch.inside_res,
                   out_ch.last_point, out_ch.status);
        end else begin
          want = expected_answers.pop_front();
          check_field("result_x", want.px, out_ch.result_x);
          check_field("result_y", want.py, out_ch.result_y);
          check_field("inside_res", 32'(want.in_poly), 32'(out_ch.inside_res));
          check_field("last_point", 32'(want.last), 32'(out_ch.last_point));
          check_field("status", 32'(want.status), 32'(out_ch.status));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_answer(op_t'(in_ch.operation), in_ch.first_vertex, in_ch.x_coord,
                       in_ch.y_coord, calc);
        // a typed-in row overrides the shadow, which still advances
        if (typed_pending) begin
          calc          = typed_want;
          typed_pending = 1'b0;
        end
        expected_answers.insert(expected_answers.size(), calc);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    drow_t                     row;
    logic [CFG_DW-1:0]         rd;
    logic [CFG_DW-1:0]         new_spacing;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] seq_x [8];
    logic signed [COORD_W-1:0] seq_y [8];
    longint                    span;
    op_t                       op;
    int unsigned               sent;
    int unsigned               kind;
    int unsigned               n;
    int unsigned               nv;
    int unsigned               k;
    int unsigned               m;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_LOAD;
    in_ch.first_vertex = 1'b0;
    in_ch.x_coord      = '0;
    in_ch.y_coord      = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // register holds its reset value before any write
    cfg_access(1'b0, '0, rd);
    check_field("grid_spacing", CFG_DW'(SPACING_RESET), rd);

    send_idle_pct = 38;
    recv_idle_pct = 46;
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.spacing_row) begin
        set_spacing(row.x);
      end else begin
        typed_pending = row.typed;
        typed_want    = row.want;
        send_item(row.op, row.first, row.x, row.y);
      end
    end

    // Random phases. Each sets a spacing (lowest, random, zero, full range,
    // moderate) and scales the polygons to it so that many scans reach their end.
    for (int phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
      case (phase_idx)
        0:       new_spacing = 32'd1;
        1:       new_spacing = $urandom_range(32'h0002_0000, 2);
        2:       new_spacing = 32'h8000_0000;    // top bit ignored, spacing becomes zero
        3:       new_spacing = $urandom();
        default: new_spacing = $urandom_range(32'h0004_0000, 1);
      endcase
      set_spacing(new_spacing);
      span = (spacing == 0) ? 64'sd4 : longint'(spacing) * 4;
      if (span > 64'sd1073741824) span = 64'sd1073741824;

      // both sides idle, then the roles swap, then a stretch with no idling
      if (phase_idx < 2) begin
        send_idle_pct = 38;
        recv_idle_pct = 46;
      end else if (phase_idx < 4) begin
        send_idle_pct = 46;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 8) begin
          // noise: any operation, any flag, any coordinates
          op = op_t'($urandom_range(3));
          send_item(op, 1'($urandom_range(1)), $urandom(), $urandom());
          if (op != OP_NONE) sent++;
        end else begin
          // well-formed sequence: new polygon, a few tests, then a scan run
          if (kind < 16)      n = $urandom_range(MAX_VERTICES + 3, MAX_VERTICES - 1);
          else if (kind < 28) n = $urandom_range(2, 1);
          else                n = $urandom_range(8, 3);
          nv = (n < 8) ? n : 8;
          for (k = 0; k < n; k++) begin
            px = rand_coord(span);
            py = rand_coord(span);
            if (k < 8) begin
              seq_x[k] = px;
              seq_y[k] = py;
            end
            send_item(OP_LOAD, (k == 0), px, py);
            sent++;
          end
          m = $urandom_range(6);
          for (k = 0; k < m; k++) begin
            // probe on, beside or away from the vertices
            case ($urandom_range(9))
              0, 1, 2: begin
                px = seq_x[$urandom_range(nv - 1)];
                py = seq_y[$urandom_range(nv - 1)];
              end
              3: begin
                px = seq_x[$urandom_range(nv - 1)] + $urandom_range(2) - 1;
                py = seq_y[$urandom_range(nv - 1)] + $urandom_range(2) - 1;
              end
              default: begin
                px = rand_coord(span);
                py = rand_coord(span);
              end
            endcase
            send_item(OP_TEST, 1'($urandom_range(1)), px, py);
            sent++;
          end
          m = ($urandom_range(4) == 0) ? 90 : $urandom_range(30);
          for (k = 0; k < m; k++) begin
            send_item(OP_SCAN, 1'($urandom_range(1)), $urandom(), $urandom());
            sent++;
          end
          // now and then hold the sender until the block has caught up
          if ($urandom_range(99) < 5) wait_for_results();
        end
      end
    end

    wait_for_results();
    repeat (END_WAIT) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
